[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clk edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, expr, msg) \
  `ASSERT_CLK(label, !(expr), msg)

`endif

[rtl/dlp_pkg.sv]
// ----------------------------------------------------------------------------
// dlp_pkg
// types and constants shared by the dual-ended log packer modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dlp_pkg;

  localparam int IDX_W     = 16;
  localparam int TCOUNT_W  = 12;
  localparam int ADDR_W    = 16;
  localparam int OADDR_W   = 12;
  localparam int DATA_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;
  localparam int SLOT_W    = 19;

  localparam logic [CFG_IDX_W-1:0] REG_WET_EN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_EN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX     = 2'd2;

  localparam logic ACT_WET  = 1'b0;
  localparam logic ACT_TEMP = 1'b1;

  localparam logic [IDX_W-1:0] MAX_ENTRIES_RST = 16'h8000;
  localparam logic [2:0]       POS_MASK        = 3'h7;

  typedef struct packed {
    logic                written;
    logic                is_wet;
    logic [ADDR_W-1:0]   addr;
    logic [2:0]          pos;
    logic                wet_val;
    logic [DATA_W-1:0]   sample;
    logic                full;
    logic [IDX_W-1:0]    wet_count;
    logic [TCOUNT_W-1:0] temp_count;
    logic                wet_tog;
    logic                temp_tog;
  } dec_t;

  typedef struct packed {
    logic              en_lo;
    logic              en_hi;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        lo;
    logic [7:0]        hi;
  } wr_t;

endpackage

`default_nettype wire

[rtl/dual_ended_log_packer.sv]
// ----------------------------------------------------------------------------
// dual_ended_log_packer
// two loggers sharing one byte store: wet/dry bits upward, temperature
// words downward, sticky full flag, one result per event
// ----------------------------------------------------------------------------
// channel   direction  transfer when                 content
// s_axis    in         s_axis_tvalid & s_axis_tready  one sample event
// m_axis    out        m_axis_tvalid & m_axis_tready  one result per event
// cfg       in         cfg_we                         register write
//
// one event per cycle sustained while m_axis accepts results; a result passes
// the input register, store read and result register in turn
// after reset the store is zeroed one two-byte row per cycle, all LOG_BYTES/2
// rows, with s_axis_tready low; cfg writes are taken meanwhile
// a stalled m_axis holds the result and backs up through the stages
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dual_ended_log_packer #(
  parameter int LOG_BYTES = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [dlp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dlp_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // wet_bit [0], temperature_sample [16:1]
  input  wire logic [23:0]                   s_axis_tdata,
  // action [0]
  input  wire logic [0:0]                    s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // written [0], write_address [12:1], write_data [28:13], full_flag [29],
  // wet_dry_count [45:30], temperature_count [57:46], wet_indicator [58],
  // temperature_indicator [59]
  output logic [63:0]                        m_axis_tdata
);

  logic                           s1_v;
  logic                           s1_act;
  logic                           s1_bit;
  logic [dlp_pkg::DATA_W-1:0]     s1_sample;
  logic                           s2_v;
  dlp_pkg::dec_t                  s2_dec;
  dlp_pkg::dec_t                  dec;
  dlp_pkg::wr_t                   wr;

  logic                           out_en;
  logic                           s2_en;
  logic                           s1_en;
  logic                           s1_move;
  logic                           s2_move;
  logic                           in_xfer;
  logic                           rd_en;
  logic [7:0]                     rd_byte;
  logic                           clearing;
  logic [7:0]                     merged;
  logic [dlp_pkg::DATA_W-1:0]     res_data;

  assign out_en  = !m_axis_tvalid || m_axis_tready;
  assign s2_en   = !s2_v || out_en;
  assign s1_en   = !s1_v || s2_en;
  assign s1_move = s1_v && s2_en;
  assign s2_move = s2_v && out_en;
  assign s_axis_tready = s1_en && !clearing;
  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign rd_en   = s1_move && dec.written && dec.is_wet;

  dlp_decide #(
    .LOG_BYTES (LOG_BYTES)
  ) u_decide (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (s1_move),
    .action    (s1_act),
    .wet_bit   (s1_bit),
    .sample    (s1_sample),
    .dec       (dec)
  );

  dlp_store #(
    .LOG_BYTES (LOG_BYTES)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .rd_en    (rd_en),
    .rd_addr  (dec.addr),
    .rd_byte  (rd_byte),
    .clearing (clearing)
  );

  // bit insert for wet/dry, whole word for temperature
  always_comb begin
    merged = (rd_byte & ~(8'h01 << s2_dec.pos)) | (8'(s2_dec.wet_val) << s2_dec.pos);
    wr       = '0;
    wr.addr  = s2_dec.addr;
    wr.en_lo = s2_move && s2_dec.written && (!s2_dec.is_wet || !s2_dec.addr[0]);
    wr.en_hi = s2_move && s2_dec.written && (!s2_dec.is_wet || s2_dec.addr[0]);
    wr.lo    = s2_dec.is_wet ? merged : s2_dec.sample[7:0];
    wr.hi    = s2_dec.is_wet ? merged : s2_dec.sample[15:8];
    if (!s2_dec.written) begin
      res_data = '0;
    end else if (s2_dec.is_wet) begin
      res_data = {8'h00, merged};
    end else begin
      res_data = s2_dec.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v          <= 1'b0;
      s2_v          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_v <= in_xfer;
      end
      if (s2_en) begin
        s2_v <= s1_v;
      end
      if (out_en) begin
        m_axis_tvalid <= s2_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_act    <= s_axis_tuser[0];
      s1_bit    <= s_axis_tdata[0];
      s1_sample <= s_axis_tdata[16:1];
    end
    if (s1_move) begin
      s2_dec <= dec;
    end
    if (s2_move) begin
      m_axis_tdata <= {4'h0, s2_dec.temp_tog, s2_dec.wet_tog, s2_dec.temp_count,
                       s2_dec.wet_count, s2_dec.full, res_data,
                       s2_dec.addr[dlp_pkg::OADDR_W-1:0], s2_dec.written};
    end
  end

  `ASSERT_NEVER(a_no_xfer_in_clear, clearing && s_axis_tready, "input taken during store clear")
  `ASSERT_CLK(a_temp_addr_even, s2_v && s2_dec.written && !s2_dec.is_wet |-> !s2_dec.addr[0], "odd temperature address")
  `ASSERT_NEVER(a_wet_one_lane, wr.en_lo && wr.en_hi && s2_dec.is_wet, "wet/dry write on both lanes")
  `ASSERT_CLK(a_write_on_move, wr.en_lo || wr.en_hi |-> s2_move && !clearing, "store write without stage move")

endmodule

`default_nettype wire

[rtl/dlp_store.sv]
// ----------------------------------------------------------------------------
// dlp_store
// byte log store as two byte lanes of half-depth, clear sweep after reset,
// registered byte read with bypass of the write in the same cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dlp_store #(
  parameter int LOG_BYTES = 4096
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire dlp_pkg::wr_t              wr,
  input  wire logic                      rd_en,
  input  wire logic [dlp_pkg::ADDR_W-1:0] rd_addr,
  output logic [7:0]                     rd_byte,
  output logic                           clearing
);

  localparam int ROWS  = LOG_BYTES / 2;
  localparam int ROW_W = $clog2(ROWS);

  logic [7:0] lo_mem [ROWS];
  logic [7:0] hi_mem [ROWS];

  logic [ROW_W-1:0] clr_row;
  logic [ROW_W-1:0] wr_row;
  logic [ROW_W-1:0] rd_row;
  logic             rd_lane;
  logic             fwd_lo;
  logic             fwd_hi;

  assign wr_row  = wr.addr[ROW_W:1];
  assign rd_row  = rd_addr[ROW_W:1];
  assign rd_lane = rd_addr[0];
  assign fwd_lo  = wr.en_lo && (wr_row == rd_row);
  assign fwd_hi  = wr.en_hi && (wr_row == rd_row);

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_row  <= '0;
    end else if (clearing) begin
      clr_row <= clr_row + 1'b1;
      if (clr_row == ROW_W'(ROWS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      lo_mem[clr_row] <= 8'h00;
      hi_mem[clr_row] <= 8'h00;
    end else begin
      if (wr.en_lo) begin
        lo_mem[wr_row] <= wr.lo;
      end
      if (wr.en_hi) begin
        hi_mem[wr_row] <= wr.hi;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (rd_lane) begin
        rd_byte <= fwd_hi ? wr.hi : hi_mem[rd_row];
      end else begin
        rd_byte <= fwd_lo ? wr.lo : lo_mem[rd_row];
      end
    end
  end

endmodule

`default_nettype wire

[rtl/dlp_decide.sv]
// ----------------------------------------------------------------------------
// dlp_decide
// configuration and stream state; per-event skip, full test and slot choice
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dlp_decide #(
  parameter int LOG_BYTES = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [dlp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dlp_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          take,
  input  wire logic                          action,
  input  wire logic                          wet_bit,
  input  wire logic [dlp_pkg::DATA_W-1:0]    sample,
  output dlp_pkg::dec_t                      dec
);

  localparam int SW = dlp_pkg::SLOT_W;
  localparam logic signed [SW-1:0] LB_SLOT  = SW'(LOG_BYTES);
  localparam logic signed [SW-1:0] TOP_SLOT = SW'(LOG_BYTES - 2);

  logic                        wet_en;
  logic                        temp_en;
  logic [dlp_pkg::IDX_W-1:0]   max_entries;
  logic [dlp_pkg::IDX_W-1:0]   wi;
  logic [dlp_pkg::IDX_W-1:0]   ti;
  logic                        full_mark;
  logic                        wet_tog;
  logic                        temp_tog;

  logic                        is_wet;
  logic                        go;
  logic                        f1;
  logic                        ok;
  logic                        f2;
  logic                        wrote;
  logic [dlp_pkg::IDX_W-1:0]   wi_inc;
  logic [dlp_pkg::IDX_W-1:0]   ti_inc;
  logic [dlp_pkg::IDX_W-1:0]   wi_next;
  logic [dlp_pkg::IDX_W-1:0]   ti_next;
  logic signed [SW-1:0]        bs;
  logic signed [SW-1:0]        ws;

  function automatic logic signed [SW-1:0] bit_slot(input logic [dlp_pkg::IDX_W-1:0] w);
    return $signed(SW'(w >> 3));
  endfunction

  function automatic logic signed [SW-1:0] word_slot(input logic [dlp_pkg::IDX_W-1:0] t);
    return TOP_SLOT - $signed(SW'({t, 1'b0}));
  endfunction

  function automatic logic full_test(input logic                      we,
                                     input logic                      te,
                                     input logic [dlp_pkg::IDX_W-1:0] w,
                                     input logic [dlp_pkg::IDX_W-1:0] t);
    logic signed [SW-1:0] b;
    logic signed [SW-1:0] s;
    logic                 r;
    b = bit_slot(w);
    s = word_slot(t);
    case ({we, te})
      2'b11:   r = (b >= s);
      2'b10:   r = (b >= LB_SLOT);
      2'b01:   r = s[SW-1];
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  always_comb begin
    is_wet  = (action == dlp_pkg::ACT_WET);
    bs      = bit_slot(wi);
    ws      = word_slot(ti);
    wi_inc  = wi + 1'b1;
    ti_inc  = ti + 1'b1;
    go      = is_wet ? (wet_en && (wi < max_entries)) : (temp_en && (ti < max_entries));
    f1      = full_mark || (go && full_test(wet_en, temp_en, wi, ti));
    ok      = go && !f1;
    f2      = f1 || (ok && (is_wet ? full_test(wet_en, temp_en, wi_inc, ti)
                                   : full_test(wet_en, temp_en, wi, ti_inc)));
    wrote   = ok && (is_wet ? (bs < LB_SLOT) : !ws[SW-1]);
    wi_next = (ok && is_wet) ? wi_inc : wi;
    ti_next = (ok && !is_wet) ? ti_inc : ti;

    dec            = '0;
    dec.written    = wrote;
    dec.is_wet     = is_wet;
    dec.addr       = wrote ? (is_wet ? bs[dlp_pkg::ADDR_W-1:0] : ws[dlp_pkg::ADDR_W-1:0])
                           : '0;
    dec.pos        = wi[2:0] & dlp_pkg::POS_MASK;
    dec.wet_val    = wet_bit;
    dec.sample     = sample;
    dec.full       = f2;
    dec.wet_count  = wi_next;
    dec.temp_count = ti_next[dlp_pkg::TCOUNT_W-1:0];
    dec.wet_tog    = wet_tog ^ (ok && is_wet);
    dec.temp_tog   = temp_tog ^ (ok && !is_wet);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wet_en      <= 1'b1;
      temp_en     <= 1'b1;
      max_entries <= dlp_pkg::MAX_ENTRIES_RST;
      wi          <= '0;
      ti          <= '0;
      full_mark   <= 1'b0;
      wet_tog     <= 1'b0;
      temp_tog    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          dlp_pkg::REG_WET_EN:  wet_en      <= cfg_data[0];
          dlp_pkg::REG_TEMP_EN: temp_en     <= cfg_data[0];
          dlp_pkg::REG_MAX:     max_entries <= cfg_data;
          default: ;
        endcase
      end
      if (take) begin
        wi        <= wi_next;
        ti        <= ti_next;
        full_mark <= f2;
        wet_tog   <= dec.wet_tog;
        temp_tog  <= dec.temp_tog;
      end
    end
  end

endmodule

`default_nettype wire
